// ----- rtl/morse_sample_decoder_top_assert.svh -----
// Assertion macros for the Morse sample decoder.
`ifndef MORSE_SAMPLE_DECODER_TOP_ASSERT_SVH
`define MORSE_SAMPLE_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MSD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MSD_ASSERT_NORST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MSD_ASSERT(lbl, prop, msg)
`define MSD_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

// ----- rtl/msd_pkg.sv -----
// Types, constants and the code table of the Morse sample decoder.
package msd_pkg;

   localparam int MAX_PATTERN_DEF = 7;
   localparam int SAMPLE_W        = 10;
   localparam int RUN_W           = 16;
   localparam int ASCII_W         = 7;
   localparam int TABLE_SIZE      = 37;
   localparam int CODE_W          = 8;
   localparam int CODE_LEN_W      = 4;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int REQ_DATA_W      = 16;
   localparam int RSP_DATA_W      = 8;

   localparam logic [SAMPLE_W-1:0] LEVEL_THRESHOLD_RST = 10'd512;
   localparam logic [RUN_W-1:0]    DOT_MAX_LEN_RST     = 16'd4;
   localparam logic [RUN_W-1:0]    LETTER_GAP_MAX_RST  = 16'd4;

   typedef enum logic [1:0] {
      CSR_LEVEL_THRESHOLD = 2'd0,
      CSR_DOT_MAX_LEN     = 2'd1,
      CSR_LETTER_GAP_MAX  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] level_threshold;
      logic [RUN_W-1:0]    dot_max_len;
      logic [RUN_W-1:0]    letter_gap_max;
   } cfg_type;

   typedef struct packed {
      logic [CODE_LEN_W-1:0] len;
      logic [CODE_W-1:0]     bits;
      logic [ASCII_W-1:0]    ascii;
   } code_entry_type;

   // Element i of a code is bit i, with 1 for a dash.
   localparam code_entry_type CODE_TABLE [TABLE_SIZE] = '{
      '{4'd7, 8'd0,  7'h20},
      '{4'd2, 8'd2,  7'h41},
      '{4'd4, 8'd1,  7'h42},
      '{4'd4, 8'd5,  7'h43},
      '{4'd3, 8'd1,  7'h44},
      '{4'd1, 8'd0,  7'h45},
      '{4'd4, 8'd4,  7'h46},
      '{4'd3, 8'd3,  7'h47},
      '{4'd4, 8'd0,  7'h48},
      '{4'd2, 8'd0,  7'h49},
      '{4'd4, 8'd14, 7'h4A},
      '{4'd3, 8'd5,  7'h4B},
      '{4'd4, 8'd2,  7'h4C},
      '{4'd2, 8'd3,  7'h4D},
      '{4'd2, 8'd1,  7'h4E},
      '{4'd3, 8'd7,  7'h4F},
      '{4'd4, 8'd6,  7'h50},
      '{4'd4, 8'd11, 7'h51},
      '{4'd3, 8'd2,  7'h52},
      '{4'd3, 8'd0,  7'h53},
      '{4'd1, 8'd1,  7'h54},
      '{4'd3, 8'd4,  7'h55},
      '{4'd4, 8'd8,  7'h56},
      '{4'd3, 8'd6,  7'h57},
      '{4'd4, 8'd9,  7'h58},
      '{4'd4, 8'd13, 7'h59},
      '{4'd4, 8'd3,  7'h5A},
      '{4'd5, 8'd31, 7'h30},
      '{4'd5, 8'd30, 7'h31},
      '{4'd5, 8'd28, 7'h32},
      '{4'd5, 8'd24, 7'h33},
      '{4'd5, 8'd16, 7'h34},
      '{4'd5, 8'd0,  7'h35},
      '{4'd5, 8'd1,  7'h36},
      '{4'd5, 8'd3,  7'h37},
      '{4'd5, 8'd7,  7'h38},
      '{4'd5, 8'd15, 7'h39}
   };

endpackage

// ----- rtl/msd_front.sv -----
// Front end: sample classification, run counters and letter pattern assembly.
module msd_front #(
   parameter int MAX_PATTERN = msd_pkg::MAX_PATTERN_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  msd_pkg::cfg_type                                 cfg,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  logic [msd_pkg::SAMPLE_W-1:0]                     sample,
   input  logic                                             end_of_message,
   output logic                                             q_valid,
   input  logic                                             q_ready,
   output logic [MAX_PATTERN+$clog2(MAX_PATTERN+1):0]       q_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = $clog2(MAX_PATTERN);
   localparam int PAT_W = MAX_PATTERN + LEN_W + 1;

   logic [msd_pkg::RUN_W-1:0] mark_run_ff, mark_run_in;
   logic [msd_pkg::RUN_W-1:0] gap_run_ff, gap_run_in;
   logic                      last_gap_ff, last_gap_in;
   logic [PAT_W-1:0]          pat_ff, pat_in;
   logic                      emit;
   logic [PAT_W-1:0]          letter;
   logic                      accept;

   function automatic logic [PAT_W-1:0] add_elem(input logic [PAT_W-1:0] p, input logic dash);
      logic [MAX_PATTERN-1:0] b;
      logic [LEN_W-1:0]       l;
      logic                   o;
      {o, l, b} = p;
      if (l >= LEN_W'(MAX_PATTERN)) begin
         o = 1'b1;
      end else begin
         if (dash) begin
            b[l[IDX_W-1:0]] = 1'b1;
         end
         l = l + 1'b1;
      end
      return {o, l, b};
   endfunction

   function automatic logic nonempty(input logic [PAT_W-1:0] p);
      return p[PAT_W-1] || (p[PAT_W-2 -: LEN_W] != '0);
   endfunction

   always_comb begin
      mark_run_in = mark_run_ff;
      gap_run_in  = gap_run_ff;
      last_gap_in = last_gap_ff;
      pat_in      = pat_ff;
      emit        = 1'b0;
      letter      = '0;
      if (sample <= cfg.level_threshold) begin
         if (last_gap_ff) begin
            if (gap_run_in <= cfg.letter_gap_max && mark_run_in != '0) begin
               pat_in = add_elem(pat_in, mark_run_in > cfg.dot_max_len);
            end
            mark_run_in = msd_pkg::RUN_W'(1);
            gap_run_in  = '0;
         end else if (mark_run_in != '1) begin
            mark_run_in = mark_run_in + 1'b1;
         end
         last_gap_in = 1'b0;
      end else begin
         if (last_gap_ff) begin
            if (gap_run_in != '1) begin
               gap_run_in = gap_run_in + 1'b1;
            end
         end else begin
            gap_run_in = msd_pkg::RUN_W'(1);
         end
         last_gap_in = 1'b1;
         if ({1'b0, gap_run_in} == {1'b0, cfg.letter_gap_max} + 17'd1) begin
            if (mark_run_in != '0) begin
               pat_in      = add_elem(pat_in, mark_run_in > cfg.dot_max_len);
               mark_run_in = '0;
            end
            if (nonempty(pat_in)) begin
               emit   = 1'b1;
               letter = pat_in;
               pat_in = '0;
            end
         end
      end
      if (end_of_message && !emit) begin
         if (mark_run_in != '0) begin
            pat_in      = add_elem(pat_in, mark_run_in > cfg.dot_max_len);
            mark_run_in = '0;
         end
         if (nonempty(pat_in)) begin
            emit   = 1'b1;
            letter = pat_in;
            pat_in = '0;
         end
      end
   end

   assign in_ready = q_ready;
   assign accept   = in_valid && q_ready;
   assign q_valid  = in_valid && emit;
   assign q_data   = letter;

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_run_ff <= '0;
         gap_run_ff  <= '0;
         last_gap_ff <= 1'b0;
         pat_ff      <= '0;
      end else if (accept) begin
         mark_run_ff <= mark_run_in;
         gap_run_ff  <= gap_run_in;
         last_gap_ff <= last_gap_in;
         pat_ff      <= pat_in;
      end
   end

endmodule

// ----- rtl/msd_queue.sv -----
// Two-entry queue that carries closed letters from the front end to the back end.
module msd_queue #(
   parameter int WIDTH = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = msd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/msd_back.sv -----
// Back end: table match of a closed letter and the registered result stage.
module msd_back #(
   parameter int MAX_PATTERN = msd_pkg::MAX_PATTERN_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       q_valid,
   output logic                                       q_ready,
   input  logic [MAX_PATTERN+$clog2(MAX_PATTERN+1):0] q_data,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [msd_pkg::ASCII_W-1:0]                rsp_ascii,
   output logic                                       rsp_invalid
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic [MAX_PATTERN-1:0]            pat_bits;
   logic [LEN_W-1:0]                  pat_len;
   logic                              pat_ovf;
   logic [msd_pkg::CODE_W-1:0]        bits_ext;
   logic [msd_pkg::CODE_LEN_W-1:0]    len_ext;
   logic                              hit;
   logic [msd_pkg::ASCII_W-1:0]       ascii;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [msd_pkg::ASCII_W-1:0]       ascii_ff;
   logic                              invalid_ff;
   logic                              load;

   assign {pat_ovf, pat_len, pat_bits} = q_data;
   assign bits_ext = msd_pkg::CODE_W'(pat_bits);
   assign len_ext  = msd_pkg::CODE_LEN_W'(pat_len);

   always_comb begin
      hit   = 1'b0;
      ascii = '0;
      for (int k = 0; k < msd_pkg::TABLE_SIZE; k++) begin
         if (msd_pkg::CODE_TABLE[k].len == len_ext && msd_pkg::CODE_TABLE[k].bits == bits_ext) begin
            hit   = 1'b1;
            ascii = ascii | msd_pkg::CODE_TABLE[k].ascii;
         end
      end
      if (pat_ovf) begin
         hit   = 1'b0;
         ascii = '0;
      end
   end

   assign q_ready = !rsp_valid_ff || rsp_ready;
   assign load    = q_valid && q_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ascii_ff   <= ascii;
         invalid_ff <= !hit;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_ascii   = ascii_ff;
   assign rsp_invalid = invalid_ff;

endmodule

// ----- rtl/morse_sample_decoder_top.sv -----
// Top level of the Morse sample decoder: register file, front end, queue and back end.
//
// Channel  Direction  Payload
// req      in         tdata[9:0] sample, tlast end_of_message
// rsp      out        tdata[6:0] symbol_ascii, tuser invalid_pattern
// csr      in/out     APB registers: threshold 0x0, dot length 0x4, letter gap 0x8
//
// One sample per cycle while the queue has room; a letter is queued, then registered.
// The two-entry queue between the front and back ends sets how long a stalled output may hold.
// Reset is synchronous; no clearing pass follows it.
// The input stalls only while the queue is full.
`include "morse_sample_decoder_top_assert.svh"
module morse_sample_decoder_top #(
   parameter int MAX_PATTERN = msd_pkg::MAX_PATTERN_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [msd_pkg::REQ_DATA_W-1:0]     req_tdata,   // sample
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [msd_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // symbol_ascii
   output logic                               rsp_tuser,   // invalid_pattern
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [msd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [msd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [msd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int PAT_W = MAX_PATTERN + $clog2(MAX_PATTERN + 1) + 1;

   logic [msd_pkg::SAMPLE_W-1:0]  level_threshold_ff;
   logic [msd_pkg::RUN_W-1:0]     dot_max_len_ff;
   logic [msd_pkg::RUN_W-1:0]     letter_gap_max_ff;
   msd_pkg::cfg_type              cfg;
   msd_pkg::csr_index_type        csr_index;
   logic                          csr_wr;
   logic                          push_valid;
   logic                          push_ready;
   logic [PAT_W-1:0]              push_data;
   logic                          pop_valid;
   logic                          pop_ready;
   logic [PAT_W-1:0]              pop_data;
   logic [msd_pkg::ASCII_W-1:0]   rsp_ascii;

   assign csr_pready = 1'b1;
   assign csr_index  = msd_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_threshold_ff <= msd_pkg::LEVEL_THRESHOLD_RST;
         dot_max_len_ff     <= msd_pkg::DOT_MAX_LEN_RST;
         letter_gap_max_ff  <= msd_pkg::LETTER_GAP_MAX_RST;
      end else if (csr_wr) begin
         case (csr_index)
            msd_pkg::CSR_LEVEL_THRESHOLD: begin
               level_threshold_ff <= csr_pwdata[msd_pkg::SAMPLE_W-1:0];
            end
            msd_pkg::CSR_DOT_MAX_LEN: begin
               dot_max_len_ff <= csr_pwdata[msd_pkg::RUN_W-1:0];
            end
            msd_pkg::CSR_LETTER_GAP_MAX: begin
               letter_gap_max_ff <= csr_pwdata[msd_pkg::RUN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         msd_pkg::CSR_LEVEL_THRESHOLD: csr_prdata = msd_pkg::CSR_DATA_W'(level_threshold_ff);
         msd_pkg::CSR_DOT_MAX_LEN:     csr_prdata = msd_pkg::CSR_DATA_W'(dot_max_len_ff);
         msd_pkg::CSR_LETTER_GAP_MAX:  csr_prdata = msd_pkg::CSR_DATA_W'(letter_gap_max_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   assign cfg.level_threshold = level_threshold_ff;
   assign cfg.dot_max_len     = dot_max_len_ff;
   assign cfg.letter_gap_max  = letter_gap_max_ff;

   msd_front #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .sample         (req_tdata[msd_pkg::SAMPLE_W-1:0]),
      .end_of_message (req_tlast),
      .q_valid        (push_valid),
      .q_ready        (push_ready),
      .q_data         (push_data)
   );

   msd_queue #(
      .WIDTH(PAT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   msd_back #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (pop_valid),
      .q_ready     (pop_ready),
      .q_data      (pop_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_ascii   (rsp_ascii),
      .rsp_invalid (rsp_tuser)
   );

   assign rsp_tdata = msd_pkg::RSP_DATA_W'(rsp_ascii);

   `MSD_ASSERT(a_invalid_has_no_symbol, rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'h00, "invalid result carries a symbol")
   `MSD_ASSERT(a_valid_symbol_set, rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'h20 || (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) || (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h5A), "decoded symbol outside the alphabet")
   `MSD_ASSERT_NORST(a_reset_clears_output, $past(reset) |-> !rsp_tvalid, "result valid right after reset")
   `MSD_ASSERT(a_threshold_write, $past(csr_wr && !reset && csr_index == msd_pkg::CSR_LEVEL_THRESHOLD) |-> level_threshold_ff == $past(csr_pwdata[9:0]), "threshold write lost")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the Morse sample decoder: directed and random stimulus.
`timescale 1ns / 100ps
module tb_top;

   localparam int MAX_ELEMENTS  = msd_pkg::MAX_PATTERN_DEF;
   localparam int SYMBOL_COUNT  = 37;
   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_TAIL    = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int PRINT_LIMIT   = 40;

   typedef struct packed {
      logic [6:0] ascii;
      logic       bad;
   } decoded_symbol_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [9:0] sample, [15:10] zero
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [6:0] symbol_ascii, [7] zero
   logic        rsp_tuser;        // [0] invalid_pattern
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   string morse_code [SYMBOL_COUNT] = '{
      ".......", ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
      ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...",
      "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
      "-----", ".----", "..---", "...--", "....-", ".....",
      "-....", "--...", "---..", "----."
   };
   string morse_text = " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

   logic [9:0]  cfg_threshold = msd_pkg::LEVEL_THRESHOLD_RST;
   logic [15:0] cfg_dot_max   = msd_pkg::DOT_MAX_LEN_RST;
   logic [15:0] cfg_gap_max   = msd_pkg::LETTER_GAP_MAX_RST;

   logic [15:0] mark_len  = '0;
   logic [15:0] gap_len   = '0;
   bit          prev_gap  = 1'b0;
   logic [6:0]  elem_bits = '0;
   int          elem_count = 0;
   bit          elem_over = 1'b0;

   decoded_symbol_type pending_symbols[$];

   int  error_count = 0;
   int  item_count = 0;
   int  results_seen = 0;
   int  settings_count = 0;
   int  idle_cycles = 0;
   int  hold_req = 0;
   int  hold_seen = 0;
   int  stall_left = 0;
   bit  steady_mode = 1'b0;

   morse_sample_decoder_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      if (steady_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $error("%s: expected %0d, got %0d", what, want, got);
      end
   endtask

   function automatic void append_element();
      if (mark_len == 0) return;
      if (elem_count >= MAX_ELEMENTS) begin
         elem_over = 1'b1;
      end else begin
         if (mark_len > cfg_dot_max) elem_bits[elem_count] = 1'b1;
         elem_count++;
      end
      mark_len = '0;
   endfunction

   function automatic bit close_letter(output decoded_symbol_type sym);
      bit    same;
      bit    hit;
      string code;
      byte   ch;
      sym.ascii = '0;
      sym.bad   = 1'b1;
      hit = 1'b0;
      if (elem_count == 0 && !elem_over) return 1'b0;
      if (!elem_over) begin
         for (int k = 0; k < SYMBOL_COUNT; k++) begin
            code = morse_code[k];
            if (!hit && code.len() == elem_count) begin
               same = 1'b1;
               for (int j = 0; j < elem_count; j++) begin
                  if ((code[j] == "-") != elem_bits[j]) same = 1'b0;
               end
               if (same) begin
                  ch = morse_text[k];
                  sym.ascii = ch[6:0];
                  sym.bad   = 1'b0;
                  hit = 1'b1;
               end
            end
         end
      end
      elem_bits  = '0;
      elem_count = 0;
      elem_over  = 1'b0;
      return 1'b1;
   endfunction

   task automatic decode_sample(input logic [9:0] level, input bit eom);
      decoded_symbol_type sym;
      bit produced;
      produced = 1'b0;
      if (level <= cfg_threshold) begin
         if (prev_gap) begin
            if (gap_len <= cfg_gap_max) append_element();
            mark_len = 16'd1;
            gap_len  = '0;
         end else if (mark_len != 16'hFFFF) begin
            mark_len++;
         end
         prev_gap = 1'b0;
      end else begin
         if (!prev_gap) begin
            gap_len = 16'd1;
         end else if (gap_len != 16'hFFFF) begin
            gap_len++;
         end
         prev_gap = 1'b1;
         if (int'(gap_len) == int'(cfg_gap_max) + 1) begin
            append_element();
            produced = close_letter(sym);
         end
      end
      if (eom && !produced) begin
         append_element();
         produced = close_letter(sym);
      end
      if (produced) pending_symbols.push_back(sym);
   endtask

   task automatic send_sample(input logic [9:0] level, input bit eom);
      int idle;
      idle = pick_gap();
      if (idle != 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, level};
      req_tlast  <= eom;
      do @(posedge clock); while (!req_tready);
      item_count++;
      decode_sample(level, eom);
   endtask

   task automatic drain_symbols();
      req_tvalid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic read_back_csr(input msd_pkg::csr_index_type idx, input logic [31:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) report_mismatch(idx.name(), want, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_csr(input msd_pkg::csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         msd_pkg::CSR_LEVEL_THRESHOLD: cfg_threshold = value[9:0];
         msd_pkg::CSR_DOT_MAX_LEN:     cfg_dot_max   = value[15:0];
         msd_pkg::CSR_LETTER_GAP_MAX:  cfg_gap_max   = value[15:0];
         default: ;
      endcase
      @(posedge clock);
      read_back_csr(idx, value);
   endtask

   task automatic set_config(input logic [9:0] thr, input logic [15:0] dot,
                             input logic [15:0] gap);
      drain_symbols();
      write_csr(msd_pkg::CSR_LEVEL_THRESHOLD, {22'b0, thr});
      write_csr(msd_pkg::CSR_DOT_MAX_LEN, {16'b0, dot});
      write_csr(msd_pkg::CSR_LETTER_GAP_MAX, {16'b0, gap});
      settings_count++;
   endtask

   task automatic send_run(input bit is_mark, input int len, input bit eom_last);
      logic [9:0] level;
      for (int i = 0; i < len; i++) begin
         if (is_mark) begin
            level = 10'($urandom_range(0, cfg_threshold));
         end else if (cfg_threshold == 10'h3FF) begin
            level = 10'h3FF;
         end else begin
            level = 10'($urandom_range(int'(cfg_threshold) + 1, 1023));
         end
         send_sample(level, eom_last && (i == len - 1));
      end
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_sample(10'($urandom_range(0, 1023)), $urandom_range(0, 7) == 0);
   endtask

   // A table letter or, now and then, a random shape of one to nine elements, with random
   // run lengths; now and then an inner gap is stretched past the limit so the letter splits.
   task automatic send_letter();
      logic [8:0] shape;
      int n_elem;
      int pick;
      int len;
      int ending;
      bit last;
      string code;
      shape = '0;
      if ($urandom_range(0, 3) != 0) begin
         pick = $urandom_range(0, SYMBOL_COUNT - 1);
         code = morse_code[pick];
         n_elem = code.len();
         for (int j = 0; j < n_elem; j++) shape[j] = (code[j] == "-");
      end else begin
         n_elem = $urandom_range(1, 9);
         shape = 9'($urandom);
      end
      ending = $urandom_range(0, 2);
      for (int k = 0; k < n_elem; k++) begin
         last = (k == n_elem - 1);
         if (shape[k]) begin
            len = (cfg_dot_max < 8) ? int'(cfg_dot_max) + 1 + $urandom_range(0, 2)
                                    : $urandom_range(1, 6);
         end else begin
            len = (cfg_dot_max == 0) ? 1
                : $urandom_range(1, (cfg_dot_max < 6) ? int'(cfg_dot_max) : 6);
         end
         send_run(1'b1, len, last && ending == 0);
         if (!last) begin
            if (cfg_gap_max < 8 && $urandom_range(0, 9) == 0) begin
               len = int'(cfg_gap_max) + 1;
            end else begin
               len = (cfg_gap_max == 0) ? 1
                   : $urandom_range(1, (cfg_gap_max < 4) ? int'(cfg_gap_max) : 4);
            end
            send_run(1'b0, len, 1'b0);
         end
      end
      if (ending == 1) begin
         send_run(1'b0, $urandom_range(1, 2), 1'b1);
      end else if (ending == 2) begin
         len = (cfg_gap_max < 8) ? int'(cfg_gap_max) + 1 + $urandom_range(0, 2) : 2;
         send_run(1'b0, len, cfg_gap_max >= 8);
      end
   endtask

   task automatic test_reset_values();
      read_back_csr(msd_pkg::CSR_LEVEL_THRESHOLD, {22'b0, msd_pkg::LEVEL_THRESHOLD_RST});
      read_back_csr(msd_pkg::CSR_DOT_MAX_LEN, {16'b0, msd_pkg::DOT_MAX_LEN_RST});
      read_back_csr(msd_pkg::CSR_LETTER_GAP_MAX, {16'b0, msd_pkg::LETTER_GAP_MAX_RST});
   endtask

   // Runs at reset settings: threshold 512, dot up to 4, letter gap up to 4.
   task automatic test_directed_cases();
      send_sample(10'd1023, 1'b1);
      send_sample(10'd512, 1'b1);
      repeat (5) send_sample(10'd0, 1'b0);
      repeat (5) send_sample(10'd1000, 1'b0);
      send_sample(10'd0, 1'b0);
      repeat (4) send_sample(10'd513, 1'b0);
      send_sample(10'd513, 1'b1);
      drain_symbols();
   endtask

   task automatic test_pattern_overflow();
      for (int i = 0; i < 8; i++) begin
         send_sample(10'd0, i == 7);
         if (i < 7) send_sample(10'd900, 1'b0);
      end
      drain_symbols();
   endtask

   task automatic test_output_backpressure();
      hold_req <= hold_req + 1;
      steady_mode = 1'b1;
      repeat (24) send_sample(10'd0, 1'b1);
      steady_mode = 1'b0;
      drain_symbols();
   endtask

   task automatic test_random_letters(input logic [9:0] thr, input logic [15:0] dot,
                                      input logic [15:0] gap, input int budget,
                                      input bit steady);
      int first;
      set_config(thr, dot, gap);
      steady_mode = steady;
      first = item_count;
      while (item_count - first < budget) begin
         if ($urandom_range(0, 4) == 0) begin
            send_noise($urandom_range(1, 6));
         end else begin
            send_letter();
         end
      end
      steady_mode = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (hold_seen != hold_req) begin
         hold_seen  <= hold_req;
         stall_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin : check_symbols
      decoded_symbol_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_symbols.size() == 0) begin
            error_count++;
            if (error_count <= PRINT_LIMIT) begin
               $error("result transaction with no symbol pending: ascii %0d, invalid %0d",
                      rsp_tdata[6:0], rsp_tuser);
            end
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_tdata[6:0] !== want.ascii) begin
               report_mismatch("symbol_ascii", want.ascii, rsp_tdata[6:0]);
            end
            if (rsp_tuser !== want.bad) begin
               report_mismatch("invalid_pattern", want.bad, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed_cases();
      test_pattern_overflow();
      test_output_backpressure();
      test_random_letters(msd_pkg::LEVEL_THRESHOLD_RST, msd_pkg::DOT_MAX_LEN_RST,
                          msd_pkg::LETTER_GAP_MAX_RST, 120, 1'b0);
      test_random_letters(10'd0, 16'd0, 16'd0, 120, 1'b0);
      test_random_letters(10'd1023, 16'd2, 16'd3, 100, 1'b0);
      test_random_letters(10'd700, 16'hFFFF, 16'hFFFF, 100, 1'b1);
      test_random_letters(10'($urandom_range(100, 900)), 16'($urandom_range(1, 5)),
                          16'($urandom_range(1, 5)), 120, 1'b0);
      drain_symbols();
      $display("Sent %0d samples and checked %0d decoded symbols over %0d register settings.",
               item_count, results_seen, settings_count);
      $display("Covered table letters, pattern overflow, output stalls and random noise.");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
